@@ rtl/rlp_pkg.sv @@
package rlp_pkg;

   // Mantissa in Q1.30 as it runs through the log and power cells.
   typedef logic [30:0] q30_type;

   localparam int MAX_SIDE = 4096;
   localparam int NUM_STAGES = 59;
   localparam int NUM_CELLS = 16;

   localparam q30_type ONE_Q30 = 31'h4000_0000;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [26:0] EXP_LIMIT = 27'h400_0000;

   // 2^(2^-(i+1)) in Q1.30, one entry per power cell.
   localparam q30_type POW2_TAB [NUM_CELLS] = '{
      31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
      31'd1097253709, 31'd1085434106, 31'd1079572137, 31'd1076653033,
      31'd1075196443, 31'd1074468887, 31'd1074105295, 31'd1073923543,
      31'd1073832681, 31'd1073787251, 31'd1073764537, 31'd1073753180
   };

   typedef enum logic [2:0] {
      REG_MODE   = 3'd0,
      REG_WIDTH  = 3'd1,
      REG_HEIGHT = 3'd2,
      REG_GSCALE = 3'd3,
      REG_IRAD   = 3'd4,
      REG_IIDX   = 3'd5,
      REG_SB     = 3'd6,
      REG_SAMP   = 3'd7
   } reg_idx_type;

   // Data that travels beside the two log2 lanes.
   typedef struct packed {
      logic [26:0] gz;
      logic [4:0]  ea;
      logic [4:0]  eb;
      logic        zb;
   } lg_side_type;

   // Data that travels beside the first power lane.
   typedef struct packed {
      logic [26:0]       gz;
      logic signed [7:0] ip;
      logic [15:0]       frac;
      logic              force_p;
      logic              force_one;
   } p1_side_type;

endpackage

@@ rtl/rlp_log2_cell.sv @@
module rlp_log2_cell (
   input  logic             clock,
   input  logic             en,
   input  rlp_pkg::q30_type mant,
   input  logic [15:0]      frac,
   output rlp_pkg::q30_type mant_out,
   output logic [15:0]      frac_out
);
   import rlp_pkg::*;

   logic [61:0] sq;
   logic [31:0] sq_hi;
   q30_type     mant_in, mant_ff;
   logic [15:0] frac_in, frac_ff;

   // One fraction bit per cell: square, and renormalize when the square reaches two.
   always_comb begin
      sq    = 62'(mant) * 62'(mant);
      sq_hi = sq[61:30];
      if (sq_hi[31]) begin
         mant_in = sq_hi[31:1];
         frac_in = {frac[14:0], 1'b1};
      end else begin
         mant_in = sq_hi[30:0];
         frac_in = {frac[14:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mant_ff <= mant_in;
         frac_ff <= frac_in;
      end
   end

   assign mant_out = mant_ff;
   assign frac_out = frac_ff;

endmodule

@@ rtl/rlp_pow2_cell.sv @@
module rlp_pow2_cell (
   input  logic             clock,
   input  logic             en,
   input  logic             apply,
   input  rlp_pkg::q30_type coef,
   input  rlp_pkg::q30_type mant,
   output rlp_pkg::q30_type mant_out
);
   import rlp_pkg::*;

   logic [62:0] prod;
   q30_type     mant_in, mant_ff;

   // Multiply in this cell's root of two when its exponent bit is set.
   always_comb begin
      prod    = 63'(mant) * 63'(coef) + 63'(64'h2000_0000);
      mant_in = apply ? prod[60:30] : mant;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mant_ff <= mant_in;
      end
   end

   assign mant_out = mant_ff;

endmodule

@@ rtl/radial_light_profile_pixel_unit.sv @@
// Radial light profile pixel unit.
// The req_ stream carries one pixel coordinate per transaction; the rsp_ stream
// returns exactly one 8-bit brightness per accepted transaction, in order.
// The pixel is offset from the image center and its squared distance is
// turned into a Gaussian or a Sersic brightness, selected by the csr_ port.
// The csr_ port is an APB-style register file of eight registers at byte
// addresses 0, 4, ... 28; it should be written only while the unit is idle.
// The datapath is a fixed pipeline of 59 stages, most of them a row of
// identical cells: two rows of 16 log2 squaring cells and two rows of 16
// power-of-two cells, each cell owning one bit of the exponent or fraction.
// A result passes through every pipeline stage and then the output register
// before rsp_tvalid; one transaction is accepted every cycle while req_tready is high.
// Reset clears the pipeline valid bits and the output valid flag and loads
// the register defaults (Gaussian mode, 256 by 256 image, all scales 1.0).
// When the receiver stalls, the result waits in the output register; the
// pipeline keeps moving until a valid result reaches its last stage, and
// only then does req_tready drop.
module radial_light_profile_pixel_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pixel_row [11:0], pixel_col [23:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // brightness [7:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rlp_pkg::*;

   // Configuration registers.
   logic        mode_ff;
   logic [12:0] width_ff, height_ff;
   logic [31:0] gscale_ff, irad_ff, iidx_ff, sb_ff, samp_ff;
   reg_idx_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_idx_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         width_ff  <= 13'd256;
         height_ff <= 13'd256;
         gscale_ff <= 32'h0001_0000;
         irad_ff   <= 32'h0001_0000;
         iidx_ff   <= 32'h0001_0000;
         sb_ff     <= 32'h0001_0000;
         samp_ff   <= 32'h0001_0000;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_idx)
            REG_MODE:   mode_ff   <= csr_pwdata[0];
            REG_WIDTH:  width_ff  <= csr_pwdata[12:0];
            REG_HEIGHT: height_ff <= csr_pwdata[12:0];
            REG_GSCALE: gscale_ff <= csr_pwdata;
            REG_IRAD:   irad_ff   <= csr_pwdata;
            REG_IIDX:   iidx_ff   <= csr_pwdata;
            REG_SB:     sb_ff     <= csr_pwdata;
            REG_SAMP:   samp_ff   <= csr_pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MODE:   csr_prdata = {31'b0, mode_ff};
         REG_WIDTH:  csr_prdata = {19'b0, width_ff};
         REG_HEIGHT: csr_prdata = {19'b0, height_ff};
         REG_GSCALE: csr_prdata = gscale_ff;
         REG_IRAD:   csr_prdata = irad_ff;
         REG_IIDX:   csr_prdata = iidx_ff;
         REG_SB:     csr_prdata = sb_ff;
         REG_SAMP:   csr_prdata = samp_ff;
      endcase
   end

   // Pipeline flow control. The whole pipeline advances together unless a finished
   // result sits in the last stage with the output register still full and rsp_tready low.
   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic                  en;
   logic                  out_vld_ff;
   logic [7:0]            out_ff, out_in;

   assign en         = !vld_ff[NUM_STAGES-1] || !out_vld_ff || rsp_tready;
   assign req_tready = en;
   assign vld_in     = {vld_ff[NUM_STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 0: capture the coordinate.
   logic [11:0] row_ff, col_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         row_ff <= req_tdata[11:0];
         col_ff <= req_tdata[23:12];
      end
   end

   // Stage 1: offset from the center, with oversized sides clamped.
   logic [12:0]        w_eff, h_eff;
   logic signed [13:0] x_ff, x_in, y_ff, y_in;

   always_comb begin
      w_eff = (width_ff > 13'(MAX_SIDE)) ? 13'(MAX_SIDE) : width_ff;
      h_eff = (height_ff > 13'(MAX_SIDE)) ? 13'(MAX_SIDE) : height_ff;
      x_in  = $signed({2'b0, col_ff}) - $signed({2'b0, w_eff[12:1]});
      y_in  = $signed({2'b0, row_ff}) - $signed({2'b0, h_eff[12:1]});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   // Stage 2: squared distance.
   logic signed [27:0] xx, yy;
   logic [24:0]        d2_ff, d2_in;

   always_comb begin
      xx    = x_ff * x_ff;
      yy    = y_ff * y_ff;
      d2_in = 25'(xx) + 25'(yy);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff <= d2_in;
      end
   end

   // Stage 3: Gaussian exponent, and normalization of both log2 operands.
   function automatic logic [4:0] msb_pos(input logic [31:0] v);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            p = 5'(i);
         end
      end
      return p;
   endfunction

   function automatic q30_type norm_mant(input logic [31:0] v, input logic [4:0] e);
      logic [62:0] sh;
      sh = 63'(v) << (5'd30 - e);
      if (e == 5'd31) begin
         return v[31:1];
      end
      return sh[30:0];
   endfunction

   logic [56:0] gt;
   logic [4:0]  ea, eb;
   q30_type     ya3_ff, ya3_in, yb3_ff, yb3_in;
   lg_side_type side3_ff, side3_in;

   always_comb begin
      gt             = 57'(d2_ff) * 57'(gscale_ff);
      ea             = msb_pos(32'(d2_ff));
      eb             = msb_pos(irad_ff);
      ya3_in         = norm_mant(32'(d2_ff), ea);
      yb3_in         = norm_mant(irad_ff, eb);
      side3_in.gz    = (gt > 57'(EXP_LIMIT)) ? EXP_LIMIT : gt[26:0];
      side3_in.ea    = ea;
      side3_in.eb    = eb;
      side3_in.zb    = (d2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ya3_ff   <= ya3_in;
         yb3_ff   <= yb3_in;
         side3_ff <= side3_in;
      end
   end

   // Stages 4 to 19: two rows of log2 cells, one for the distance and one for
   // the radius scale, with the side data shifted alongside.
   q30_type     lga_y [NUM_CELLS+1];
   q30_type     lgb_y [NUM_CELLS+1];
   logic [15:0] lga_f [NUM_CELLS+1];
   logic [15:0] lgb_f [NUM_CELLS+1];
   lg_side_type lg_side [NUM_CELLS+1];
   lg_side_type lg_side_ff [NUM_CELLS];

   assign lga_y[0]   = ya3_ff;
   assign lgb_y[0]   = yb3_ff;
   assign lga_f[0]   = '0;
   assign lgb_f[0]   = '0;
   assign lg_side[0] = side3_ff;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_log2
      rlp_log2_cell u_lga (
         .clock    (clock),
         .en       (en),
         .mant     (lga_y[i]),
         .frac     (lga_f[i]),
         .mant_out (lga_y[i+1]),
         .frac_out (lga_f[i+1])
      );
      rlp_log2_cell u_lgb (
         .clock    (clock),
         .en       (en),
         .mant     (lgb_y[i]),
         .frac     (lgb_f[i]),
         .mant_out (lgb_y[i+1]),
         .frac_out (lgb_f[i+1])
      );
      always_ff @(posedge clock) begin
         if (en) begin
            lg_side_ff[i] <= lg_side[i];
         end
      end
      assign lg_side[i+1] = lg_side_ff[i];
   end

   // Stage 20: log2 of the scaled radius squared, S = log2(d2) + 2 log2(q).
   logic [20:0]        la, lb;
   logic signed [24:0] s_ff, s_in;
   logic [26:0]        gz20_ff;
   logic               zb20_ff;

   always_comb begin
      la   = {lg_side[NUM_CELLS].ea, lga_f[NUM_CELLS]};
      lb   = {lg_side[NUM_CELLS].eb, lgb_f[NUM_CELLS]};
      s_in = $signed({4'b0, la}) + $signed({3'b0, lb, 1'b0}) - 25'sd2097152;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff    <= s_in;
         gz20_ff <= lg_side[NUM_CELLS].gz;
         zb20_ff <= lg_side[NUM_CELLS].zb;
      end
   end

   // Stage 21: exponent of the power, e = m*S/2, clamped, and the forced cases.
   logic [23:0]        sm;
   logic [56:0]        emul;
   logic [39:0]        em;
   logic [22:0]        em_c;
   logic signed [23:0] e_val;
   p1_side_type        side21_ff, side21_in;

   always_comb begin
      sm   = s_ff[24] ? 24'(-s_ff) : 24'(s_ff);
      emul = 57'(iidx_ff) * 57'(sm) + 57'(64'h1_0000);
      em   = emul[56:17];
      if (s_ff[24]) begin
         em_c  = (em > 40'h40_0000) ? 23'h40_0000 : em[22:0];
         e_val = -$signed({1'b0, em_c});
      end else begin
         em_c  = (em > 40'h1D_0000) ? 23'h1D_0000 : em[22:0];
         e_val = $signed({1'b0, em_c});
      end
      side21_in.gz        = gz20_ff;
      side21_in.ip        = e_val[23:16];
      side21_in.frac      = e_val[15:0];
      side21_in.force_p   = zb20_ff || (irad_ff == '0) || (iidx_ff == '0);
      side21_in.force_one = (iidx_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side21_ff <= side21_in;
      end
   end

   // Stages 22 to 37: power-of-two cells for the fraction of e.
   q30_type     p1_y [NUM_CELLS+1];
   p1_side_type p1_side [NUM_CELLS+1];
   p1_side_type p1_side_ff [NUM_CELLS];

   assign p1_y[0]    = ONE_Q30;
   assign p1_side[0] = side21_ff;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_pow_a
      rlp_pow2_cell u_cell (
         .clock    (clock),
         .en       (en),
         .apply    (p1_side[i].frac[NUM_CELLS-1-i]),
         .coef     (POW2_TAB[i]),
         .mant     (p1_y[i]),
         .mant_out (p1_y[i+1])
      );
      always_ff @(posedge clock) begin
         if (en) begin
            p1_side_ff[i] <= p1_side[i];
         end
      end
      assign p1_side[i+1] = p1_side_ff[i];
   end

   // Stage 38: p = round(2^e) in Q16.16, then |1 - p| and its sign.
   logic [46:0]       p_prod, p_shv, p_val;
   logic [47:0]       p_rnd;
   logic signed [8:0] p_amt;
   logic [46:0]       dmag38_ff, dmag38_in;
   logic              dneg38_ff, dneg38_in;
   logic [26:0]       gz38_ff;

   always_comb begin
      p_prod = {p1_y[NUM_CELLS], 16'b0};
      p_amt  = 9'sd29 - $signed({p1_side[NUM_CELLS].ip[7], p1_side[NUM_CELLS].ip});
      p_shv  = p_prod >> p_amt[6:0];
      p_rnd  = (48'(p_shv) + 48'd1) >> 1;
      if (p1_side[NUM_CELLS].force_p) begin
         p_val = p1_side[NUM_CELLS].force_one ? 47'h1_0000 : '0;
      end else begin
         p_val = p_rnd[46:0];
      end
      dneg38_in = (p_val > 47'h1_0000);
      dmag38_in = dneg38_in ? (p_val - 47'h1_0000) : (47'h1_0000 - p_val);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dmag38_ff <= dmag38_in;
         dneg38_ff <= dneg38_in;
         gz38_ff   <= p1_side[NUM_CELLS].gz;
      end
   end

   // Stage 39: high partial product of b * |1 - p|.
   logic [62:0] ph39_ff, ph39_in;
   logic [15:0] dlo39_ff;
   logic        dneg39_ff;
   logic [26:0] gz39_ff;

   assign ph39_in = 63'(sb_ff) * 63'(dmag38_ff[46:16]);

   always_ff @(posedge clock) begin
      if (en) begin
         ph39_ff   <= ph39_in;
         dlo39_ff  <= dmag38_ff[15:0];
         dneg39_ff <= dneg38_ff;
         gz39_ff   <= gz38_ff;
      end
   end

   // Stage 40: low partial product, sum, clamp, and profile select.
   logic [47:0] pl_full;
   logic [63:0] zs;
   logic [26:0] zmag40_ff, zmag40_in;
   logic        zneg40_ff, zneg40_in;

   always_comb begin
      pl_full = 48'(sb_ff) * 48'(dlo39_ff) + 48'h8000;
      zs      = 64'(ph39_ff) + 64'(pl_full[47:16]);
      if (mode_ff) begin
         zmag40_in = (zs > 64'(EXP_LIMIT)) ? EXP_LIMIT : zs[26:0];
         zneg40_in = dneg39_ff;
      end else begin
         zmag40_in = gz39_ff;
         zneg40_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zmag40_ff <= zmag40_in;
         zneg40_ff <= zneg40_in;
      end
   end

   // Stage 41: w = round(z * log2(e)), signed Q12.16.
   logic [57:0]        wprod;
   logic [27:0]        wm;
   logic signed [27:0] w41_ff, w41_in;

   always_comb begin
      wprod  = 58'(zmag40_ff) * 58'(LOG2E_Q30) + 58'(64'h2000_0000);
      wm     = wprod[57:30];
      w41_in = zneg40_ff ? -$signed(wm) : $signed(wm);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w41_ff <= w41_in;
      end
   end

   // Stages 42 to 57: power-of-two cells for the fraction of w.
   q30_type            p2_y [NUM_CELLS+1];
   logic signed [27:0] p2_w [NUM_CELLS+1];
   logic signed [27:0] p2_w_ff [NUM_CELLS];

   assign p2_y[0] = ONE_Q30;
   assign p2_w[0] = w41_ff;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_pow_b
      rlp_pow2_cell u_cell (
         .clock    (clock),
         .en       (en),
         .apply    (p2_w[i][NUM_CELLS-1-i]),
         .coef     (POW2_TAB[i]),
         .mant     (p2_y[i]),
         .mant_out (p2_y[i+1])
      );
      always_ff @(posedge clock) begin
         if (en) begin
            p2_w_ff[i] <= p2_w[i];
         end
      end
      assign p2_w[i+1] = p2_w_ff[i];
   end

   // Stage 58: amplitude times the fractional power.
   logic [31:0] amp;
   logic [62:0] prod58_ff, prod58_in;
   logic [11:0] ip58_ff;

   assign amp       = mode_ff ? samp_ff : 32'h00FF_0000;
   assign prod58_in = 63'(amp) * 63'(p2_y[NUM_CELLS]);

   always_ff @(posedge clock) begin
      if (en) begin
         prod58_ff <= prod58_in;
         ip58_ff   <= p2_w[NUM_CELLS][27:16];
      end
   end

   // Final scaling by the integer power, rounding and saturation.
   logic signed [12:0] fsh;
   logic [12:0]        fsh_m1;
   logic [62:0]        fshv;
   logic [63:0]        frnd;

   always_comb begin
      fsh    = 13'sd46 - $signed({ip58_ff[11], ip58_ff});
      fsh_m1 = 13'(fsh - 13'sd1);
      fshv   = prod58_ff >> fsh_m1[5:0];
      frnd   = (64'(fshv) + 64'd1) >> 1;
      if (amp == '0) begin
         out_in = '0;
      end else if (fsh < 13'sd1) begin
         out_in = 8'hFF;
      end else if (fsh >= 13'sd64) begin
         out_in = '0;
      end else if (frnd > 64'd255) begin
         out_in = 8'hFF;
      end else begin
         out_in = frnd[7:0];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en && vld_ff[NUM_STAGES-1]) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en && vld_ff[NUM_STAGES-1]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

endmodule
